// ===== hw/rtl/ksort_pkg.sv =====
// Shared constants and types for the key sorter.
package ksort_pkg;
  localparam int unsigned DEF_MAX_ITEMS = 64;
  localparam int unsigned DEF_KEY_BITS  = 32;
  localparam int unsigned IO_KEY_BITS   = 32;
  localparam int unsigned MODE_BITS     = 2;
  localparam logic [MODE_BITS-1:0] MODE_ASC_U  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_DESC_U = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_ASC_S  = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_DESC_S = 2'd3;
endpackage

// ===== hw/rtl/ksort_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module ksort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/ksort_cmp.sv =====
// Order comparator: true when key a must come after key b.
module ksort_cmp
  import ksort_pkg::*;
#(
  parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
  input  logic [MODE_BITS-1:0] mode,
  input  logic [KEY_BITS-1:0]  a,
  input  logic [KEY_BITS-1:0]  b,
  output logic                 after
);
  logic [KEY_BITS-1:0] flip;
  logic [KEY_BITS-1:0] ra;
  logic [KEY_BITS-1:0] rb;

  always_comb begin
    flip = '0;
    flip[KEY_BITS-1] = mode[1];
    ra = a ^ flip;
    rb = b ^ flip;
    after = mode[0] ? (ra < rb) : (ra > rb);
  end
endmodule

// ===== hw/rtl/key_sorter.sv =====
// Top level of the key sorter: load, insertion sort in RAM, ordered drain.
// Keys of a set load one per cycle into a RAM. The transaction marked last
// starts a sort: an insertion sort over the RAM, one read or one write per
// cycle, with the key being inserted held in a register. The sort is then
// followed by draining: each result is read from the RAM (registered read)
// and then loaded into the output register, and a new read is issued only
// when the output register is empty or being taken. No input transaction
// is taken while a sort or drain runs. Keys past MAX_ITEMS are dropped and
// every result of that set carries overflow. Mode in force at the last key
// decides the order only if the user holds it until the sort ends; the
// block itself does not enforce this.
module key_sorter
  import ksort_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int unsigned KEY_BITS  = DEF_KEY_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [MODE_BITS-1:0]   cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [IO_KEY_BITS-1:0] key_in,
  input  logic                   last_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [IO_KEY_BITS-1:0] key_out,
  output logic                   last_out,
  output logic                   overflow
);
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

  localparam logic [2:0] S_LOAD  = 3'd0; // take keys
  localparam logic [2:0] S_ROUT  = 3'd1; // read key i as insert value
  localparam logic [2:0] S_RPREV = 3'd2; // read entry j-1
  localparam logic [2:0] S_CMP   = 3'd3; // compare entry j-1 with value
  localparam logic [2:0] S_DRAIN = 3'd4; // stream results

  logic [2:0]          state;
  logic [MODE_BITS-1:0] order_mode;
  logic [CW-1:0]       item_count;
  logic                dropped_flag;
  logic [CW-1:0]       i;     // outer index
  logic [CW-1:0]       j;     // hole position
  logic [KEY_BITS-1:0] v;     // key being inserted
  logic                v_ld;  // set: S_RPREV captures v from RAM
  logic [CW-1:0]       rd_cnt;  // drain: reads issued
  logic [CW-1:0]       out_cnt; // drain: results delivered
  logic                rd_pend; // drain: read data arrives this cycle

  logic                we;
  logic [AW-1:0]       waddr;
  logic [KEY_BITS-1:0] wdata;
  logic [AW-1:0]       raddr;
  logic [KEY_BITS-1:0] rdata;
  logic                after;
  logic                in_acc;
  logic                out_acc;
  logic                out_free;

  ksort_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ITEMS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  ksort_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .mode(order_mode), .a(rdata), .b(v), .after(after)
  );

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  // Output slot free when empty or being taken this cycle.
  assign out_free = !out_valid || !out_stall;

  // RAM port steering.
  always_comb begin
    we    = 1'b0;
    waddr = item_count[AW-1:0];
    wdata = KEY_BITS'(key_in);
    raddr = i[AW-1:0];
    case (state)
      S_LOAD: begin
        we = in_acc && (item_count != CAP);
      end
      S_ROUT: begin
        raddr = i[AW-1:0];
      end
      S_RPREV: begin
        raddr = AW'(j - 1'b1);
      end
      S_CMP: begin
        // shift entry j-1 into j, or drop v into the hole
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = (j != '0 && !v_ld && after) ? rdata : v;
      end
      S_DRAIN: begin
        raddr = rd_cnt[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      order_mode   <= MODE_ASC_U;
      item_count   <= '0;
      dropped_flag <= 1'b0;
      out_valid    <= 1'b0;
      i            <= '0;
      j            <= '0;
      v_ld         <= 1'b0;
      rd_cnt       <= '0;
      out_cnt      <= '0;
      rd_pend      <= 1'b0;
    end else begin
      if (cfg_we) order_mode <= cfg_wdata;
      if (out_acc) out_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (item_count != CAP) item_count <= item_count + 1'b1;
            else dropped_flag <= 1'b1;
            if (last_in) begin
              // Empty sets are impossible: the last key is stored
              // unless capacity was reached, so count is at least 1.
              i     <= CW'(1);
              state <= S_ROUT;
            end
          end
        end
        S_ROUT: begin
          if (i >= item_count) begin
            rd_cnt  <= '0;
            out_cnt <= '0;
            rd_pend <= 1'b0;
            state   <= S_DRAIN;
          end else begin
            j     <= i;
            v_ld  <= 1'b1;
            state <= S_RPREV;
          end
        end
        S_RPREV: begin
          if (v_ld) v <= rdata;  // value of entry i from last read
          v_ld  <= 1'b0;
          state <= S_CMP;
        end
        S_CMP: begin
          if (j != '0 && after) begin
            j     <= j - 1'b1;
            state <= (j == CW'(1)) ? S_CMP : S_RPREV;
            if (j == CW'(1)) v_ld <= 1'b0;
          end else begin
            i     <= i + 1'b1;
            state <= S_ROUT;
          end
          // j reaching 0: next S_CMP writes v at 0 (after is ignored)
          if (j == '0) begin
            i     <= i + 1'b1;
            state <= S_ROUT;
          end
        end
        S_DRAIN: begin
          // one read in flight at most; present data when slot is free
          if (rd_pend) begin
            out_valid <= 1'b1;
            key_out   <= IO_KEY_BITS'(rdata);
            last_out  <= (out_cnt + 1'b1 == item_count);
            overflow  <= dropped_flag;
            out_cnt   <= out_cnt + 1'b1;
            rd_pend   <= 1'b0;
            if (out_cnt + 1'b1 == item_count) begin
              item_count   <= '0;
              dropped_flag <= 1'b0;
              state        <= S_LOAD;
            end
          end else if (out_free && rd_cnt != item_count && (out_acc || !out_valid)) begin
            rd_cnt  <= rd_cnt + 1'b1;
            rd_pend <= 1'b1;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Stored count never exceeds capacity.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    item_count <= CAP) else $error("count beyond capacity");
  // Results only while draining.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DRAIN) else $error("stray result");
  // Input is never taken during sort or drain.
  a_noin: assert property (@(posedge clk) disable iff (rst)
    state != S_LOAD |-> in_stall) else $error("input taken while busy");
  // A held result is not overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_out))
    else $error("result lost");
endmodule
